// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the memory map sanitizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, idle during reset.
`define MSAN_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// Check that a condition never holds.
`define MSAN_NEVER(label, expr) \
    `MSAN_ASSERT(label, !(expr))

`endif

// File: hw/rtl/msan_pkg.sv
// Package with shared types and constants of the memory map sanitizer.
`timescale 1ns / 1ps
`default_nettype none

package msan_pkg;

    localparam int ADDR_W              = 64;
    localparam int KIND_W              = 32;
    localparam int DEFAULT_MAX_ENTRIES = 16;

    localparam logic [KIND_W-1:0] CLASH_TYPE = 32'd2;
    localparam logic [KIND_W-1:0] CLASH_ATTR = 32'd1;

    // What one sorting cell shows its neighbors
    typedef struct packed {
        logic [ADDR_W-1:0] val;
        logic              valid;
        logic              lt;
    } cell_link_t;

    // Command broadcast to the whole sorting chain
    typedef struct packed {
        logic insert;
        logic pop;
    } chain_cmd_t;

endpackage

`default_nettype wire

// File: hw/rtl/msan_cell.sv
// One cell of the sorted boundary chain.
`timescale 1ns / 1ps
`default_nettype none

module msan_cell
    import msan_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire chain_cmd_t        cmd,
    input  wire logic [ADDR_W-1:0] new_val,
    input  wire logic              dup,
    input  wire cell_link_t        prev_link,
    input  wire cell_link_t        next_link,
    output      cell_link_t        link,
    output      logic              eq
);

    logic [ADDR_W-1:0] val_reg;
    logic [ADDR_W-1:0] val_next;
    logic              valid_reg;
    logic              valid_next;
    logic              lt;

    // Compare the broadcast value against the held one
    assign lt         = !valid_reg || (new_val < val_reg);
    assign eq         = valid_reg && (new_val == val_reg);
    assign link.val   = val_reg;
    assign link.valid = valid_reg;
    assign link.lt    = lt;

    // Take the new value, shift up from the left, or shift down from the right
    always_comb
    begin
        val_next   = val_reg;
        valid_next = valid_reg;
        if (cmd.insert && !dup && lt)
        begin
            if (prev_link.lt)
            begin
                val_next   = prev_link.val;
                valid_next = prev_link.valid;
            end
            else
            begin
                val_next   = new_val;
                valid_next = 1'b1;
            end
        end
        else if (cmd.pop)
        begin
            val_next   = next_link.val;
            valid_next = next_link.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

`default_nettype wire

// File: hw/rtl/msan_chain.sv
// Row of sorting cells that keeps distinct boundaries in ascending order.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module msan_chain
    import msan_pkg::*;
#(
    parameter int NB = 2 * DEFAULT_MAX_ENTRIES
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire chain_cmd_t        cmd,
    input  wire logic [ADDR_W-1:0] new_val,
    output      logic [ADDR_W-1:0] head_val,
    output      logic              head_valid,
    output      logic              second_valid
);

    cell_link_t        links [NB];
    cell_link_t        prev_links [NB];
    cell_link_t        next_links [NB];
    logic [NB-1:0]     eqs;
    logic [NB-1:0]     valids;
    logic              dup;

    // Drop a value that is already held
    assign dup = |eqs;

    genvar k;
    generate
        for (k = 0; k < NB; k++)
        begin : g_cell
            if (k == 0)
            begin : g_first
                assign prev_links[k] = '0;
            end
            else
            begin : g_mid
                assign prev_links[k] = links[k-1];
            end
            if (k == NB - 1)
            begin : g_last
                assign next_links[k] = '0;
            end
            else
            begin : g_inner
                assign next_links[k] = links[k+1];
            end
            assign valids[k] = links[k].valid;

            msan_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .new_val   (new_val),
                .dup       (dup),
                .prev_link (prev_links[k]),
                .next_link (next_links[k]),
                .link      (links[k]),
                .eq        (eqs[k])
            );
        end
    endgenerate

    assign head_val     = links[0].val;
    assign head_valid   = links[0].valid;
    assign second_valid = (NB > 1) ? valids[(NB > 1) ? 1 : 0] : 1'b0;

    // Occupied cells always form a run from cell zero
    `MSAN_NEVER(a_chain_packed, ((valids + NB'(1)) & valids) != '0)

endmodule

`default_nettype wire

// File: hw/rtl/memory_map_sanitizer_unit.sv
// Top level of the memory map sanitizer.
// Ranges arrive one request per cycle on the s_ side until tlast; a range beyond
// MAX_ENTRIES is dropped and flagged. Processing then inserts up to two boundaries
// per stored range, those within the limit, into a sorting chain of 2*MAX_ENTRIES
// cells, and classifies each distinct boundary by scanning the range store one
// range per cycle. No input is taken during processing. Regions leave on the m_
// side in ascending order; the final one carries tlast, and an empty list gives
// one result with the empty flag set.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module memory_map_sanitizer_unit
    import msan_pkg::*;
#(
    parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // entry_addr[63:0], entry_size[127:64], entry_type[159:128], entry_ext[191:160]
    input  wire logic [191:0] s_tdata,
    input  wire logic         s_tlast,
    input  wire logic         s_tvalid,
    output      logic         s_tready,
    // region_addr[63:0], region_size[127:64], region_type[159:128], region_ext[191:160]
    output      logic [191:0] m_tdata,
    output      logic         m_tlast,
    // empty_res[0], overflowed[1]
    output      logic [1:0]   m_tuser,
    output      logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [63:0]  cfg_data,
    input  wire logic         cfg_valid,
    output      logic         cfg_ready
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int NB = 2 * MAX_ENTRIES;

    localparam logic [2:0] ST_LOAD   = 3'd0;
    localparam logic [2:0] ST_GEN    = 3'd1;
    localparam logic [2:0] ST_CLASS  = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_ENDRUN = 3'd4;
    localparam logic [2:0] ST_FIN    = 3'd5;

    // Range store
    logic [ADDR_W-1:0] rb_mem [MAX_ENTRIES];
    logic [ADDR_W-1:0] rl_mem [MAX_ENTRIES];
    logic [KIND_W-1:0] rk_mem [MAX_ENTRIES];
    logic [KIND_W-1:0] ra_mem [MAX_ENTRIES];

    logic [2:0]        state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              drop_reg, drop_next;
    logic [ADDR_W-1:0] limit_reg;
    logic [CW-1:0]     gi_reg, gi_next;
    logic              phase_reg, phase_next;
    logic [CW-1:0]     ci_reg, ci_next;
    logic              found_reg, found_next;
    logic              clash_reg, clash_next;
    logic [KIND_W-1:0] ft_reg, ft_next, fa_reg, fa_next;
    logic              open_reg, open_next;
    logic [ADDR_W-1:0] start_reg, start_next;
    logic [KIND_W-1:0] ct_reg, ct_next, ca_reg, ca_next;
    logic              pend_v_reg, pend_v_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next, pend_size_reg, pend_size_next;
    logic [KIND_W-1:0] pend_type_reg, pend_type_next, pend_ext_reg, pend_ext_next;
    logic              out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0] out_addr_reg, out_addr_next, out_size_reg, out_size_next;
    logic [KIND_W-1:0] out_type_reg, out_type_next, out_ext_reg, out_ext_next;
    logic              out_last_reg, out_last_next;
    logic              out_empty_reg, out_empty_next;
    logic              out_ovf_reg, out_ovf_next;

    logic              in_accept;
    logic              has_room;
    logic [ADDR_W-1:0] g_base, g_len, c_base, c_len, bval;
    logic [KIND_W-1:0] c_kind, c_attr, d_kind, d_attr;
    logic              c_cover, close, stall;
    logic [CW-1:0]     last_idx;
    chain_cmd_t        cmd;
    logic [ADDR_W-1:0] ins_val;
    logic              head_valid, second_valid;

    assign s_tready  = (state_reg == ST_LOAD);
    assign in_accept = s_tvalid && s_tready;
    assign has_room  = (count_reg < CW'(MAX_ENTRIES));
    assign cfg_ready = 1'b1;
    assign last_idx  = count_reg - CW'(1);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_ext_reg, out_type_reg, out_size_reg, out_addr_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_ovf_reg, out_empty_reg};

    // Read the store for boundary generation and for the coverage scan
    assign g_base = rb_mem[gi_reg[IW-1:0]];
    assign g_len  = rl_mem[gi_reg[IW-1:0]];
    assign c_base = rb_mem[ci_reg[IW-1:0]];
    assign c_len  = rl_mem[ci_reg[IW-1:0]];
    assign c_kind = rk_mem[ci_reg[IW-1:0]];
    assign c_attr = ra_mem[ci_reg[IW-1:0]];
    assign c_cover = (bval >= c_base) && ((bval - c_base) < c_len);

    assign d_kind = clash_reg ? CLASH_TYPE : ft_reg;
    assign d_attr = clash_reg ? CLASH_ATTR : fa_reg;
    assign close  = open_reg && (!found_reg || d_kind != ct_reg || d_attr != ca_reg);

    // Sorting chain of boundaries
    msan_chain #(
        .NB (NB)
    ) u_chain (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .new_val      (ins_val),
        .head_val     (bval),
        .head_valid   (head_valid),
        .second_valid (second_valid)
    );

    // Store an accepted range while the store has room
    always_ff @(posedge clk)
    begin
        if (in_accept && has_room)
        begin
            rb_mem[count_reg[IW-1:0]] <= s_tdata[63:0];
            rl_mem[count_reg[IW-1:0]] <= s_tdata[127:64];
            rk_mem[count_reg[IW-1:0]] <= s_tdata[159:128];
            ra_mem[count_reg[IW-1:0]] <= s_tdata[191:160];
        end
    end

    // Sequence loading, boundary insertion, classification and emission
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        drop_next      = drop_reg;
        gi_next        = gi_reg;
        phase_next     = phase_reg;
        ci_next        = ci_reg;
        found_next     = found_reg;
        clash_next     = clash_reg;
        ft_next        = ft_reg;
        fa_next        = fa_reg;
        open_next      = open_reg;
        start_next     = start_reg;
        ct_next        = ct_reg;
        ca_next        = ca_reg;
        pend_v_next    = pend_v_reg;
        pend_addr_next = pend_addr_reg;
        pend_size_next = pend_size_reg;
        pend_type_next = pend_type_reg;
        pend_ext_next  = pend_ext_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_addr_next  = out_addr_reg;
        out_size_next  = out_size_reg;
        out_type_next  = out_type_reg;
        out_ext_next   = out_ext_reg;
        out_last_next  = out_last_reg;
        out_empty_next = out_empty_reg;
        out_ovf_next   = out_ovf_reg;
        cmd            = '0;
        ins_val        = phase_reg ? (g_base + g_len) : g_base;
        stall          = 1'b0;

        case (state_reg)
            ST_LOAD:
            begin
                if (in_accept)
                begin
                    if (has_room)
                        count_next = count_reg + CW'(1);
                    else
                        drop_next = 1'b1;
                    if (s_tlast)
                    begin
                        gi_next    = '0;
                        phase_next = 1'b0;
                        state_next = ST_GEN;
                    end
                end
            end
            ST_GEN:
            begin
                // Insert the base when it is within the limit, then the end when it stays within the limit
                if (!phase_reg)
                    cmd.insert = (g_base <= limit_reg);
                else
                    cmd.insert = (g_base <= limit_reg) && ((limit_reg - g_base) >= g_len);
                phase_next = !phase_reg;
                if (phase_reg)
                begin
                    gi_next = gi_reg + CW'(1);
                    if (gi_reg == last_idx)
                    begin
                        ci_next    = '0;
                        found_next = 1'b0;
                        clash_next = 1'b0;
                        state_next = ST_CLASS;
                    end
                end
            end
            ST_CLASS:
            begin
                if (!head_valid)
                    state_next = ST_ENDRUN;
                else
                begin
                    // Scan ranges in load order for the head boundary
                    if (c_cover)
                    begin
                        if (!found_reg)
                        begin
                            found_next = 1'b1;
                            ft_next    = c_kind;
                            fa_next    = c_attr;
                        end
                        else if (c_kind != ft_reg || c_attr != fa_reg)
                            clash_next = 1'b1;
                    end
                    ci_next = ci_reg + CW'(1);
                    if (ci_reg == last_idx)
                        state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                stall = close && pend_v_reg && out_valid_reg;
                if (!stall)
                begin
                    if (close)
                    begin
                        if (pend_v_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_addr_next  = pend_addr_reg;
                            out_size_next  = pend_size_reg;
                            out_type_next  = pend_type_reg;
                            out_ext_next   = pend_ext_reg;
                            out_last_next  = 1'b0;
                            out_empty_next = 1'b0;
                            out_ovf_next   = drop_reg;
                        end
                        pend_v_next    = 1'b1;
                        pend_addr_next = start_reg;
                        pend_size_next = bval - start_reg;
                        pend_type_next = ct_reg;
                        pend_ext_next  = ca_reg;
                        open_next      = 1'b0;
                    end
                    if (found_reg && (!open_reg || close))
                    begin
                        open_next  = 1'b1;
                        start_next = bval;
                        ct_next    = d_kind;
                        ca_next    = d_attr;
                    end
                    cmd.pop    = 1'b1;
                    ci_next    = '0;
                    found_next = 1'b0;
                    clash_next = 1'b0;
                    state_next = second_valid ? ST_CLASS : ST_ENDRUN;
                end
            end
            ST_ENDRUN:
            begin
                // Close an open run at the limit
                stall = open_reg && pend_v_reg && out_valid_reg;
                if (!stall)
                begin
                    if (open_reg)
                    begin
                        if (pend_v_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_addr_next  = pend_addr_reg;
                            out_size_next  = pend_size_reg;
                            out_type_next  = pend_type_reg;
                            out_ext_next   = pend_ext_reg;
                            out_last_next  = 1'b0;
                            out_empty_next = 1'b0;
                            out_ovf_next   = drop_reg;
                        end
                        pend_v_next    = 1'b1;
                        pend_addr_next = start_reg;
                        pend_size_next = limit_reg - start_reg + ADDR_W'(1);
                        pend_type_next = ct_reg;
                        pend_ext_next  = ca_reg;
                    end
                    open_next  = 1'b0;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // Emit the held region as final, or the empty marker
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_addr_next  = pend_v_reg ? pend_addr_reg : '0;
                    out_size_next  = pend_v_reg ? pend_size_reg : '0;
                    out_type_next  = pend_v_reg ? pend_type_reg : '0;
                    out_ext_next   = pend_v_reg ? pend_ext_reg : '0;
                    out_last_next  = 1'b1;
                    out_empty_next = !pend_v_reg;
                    out_ovf_next   = drop_reg;
                    pend_v_next    = 1'b0;
                    count_next     = '0;
                    drop_next      = 1'b0;
                    state_next     = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            drop_reg      <= 1'b0;
            limit_reg     <= '1;
            open_reg      <= 1'b0;
            pend_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            drop_reg      <= drop_next;
            open_reg      <= open_next;
            pend_v_reg    <= pend_v_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
                limit_reg <= cfg_data;
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        gi_reg        <= gi_next;
        phase_reg     <= phase_next;
        ci_reg        <= ci_next;
        found_reg     <= found_next;
        clash_reg     <= clash_next;
        ft_reg        <= ft_next;
        fa_reg        <= fa_next;
        start_reg     <= start_next;
        ct_reg        <= ct_next;
        ca_reg        <= ca_next;
        pend_addr_reg <= pend_addr_next;
        pend_size_reg <= pend_size_next;
        pend_type_reg <= pend_type_next;
        pend_ext_reg  <= pend_ext_next;
        out_addr_reg  <= out_addr_next;
        out_size_reg  <= out_size_next;
        out_type_reg  <= out_type_next;
        out_ext_reg   <= out_ext_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
        out_ovf_reg   <= out_ovf_next;
    end

    `MSAN_NEVER(a_count_bound, count_reg > CW'(MAX_ENTRIES))
    `MSAN_ASSERT(a_load_no_pending, (state_reg == ST_LOAD) |-> (!pend_v_reg && !open_reg))
    `MSAN_ASSERT(a_fin_returns, (state_reg == ST_FIN && !out_valid_reg) |=> (state_reg == ST_LOAD && out_valid_reg && m_tlast))

endmodule

`default_nettype wire

// File: verif/msan_region_checker.sv
// Checker that predicts and compares the regions of the memory map sanitizer.
`timescale 1ns / 1ps
`default_nettype none

module msan_region_checker
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic [191:0] s_tdata,
    input  wire logic         s_tlast,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [191:0] m_tdata,
    input  wire logic         m_tlast,
    input  wire logic [1:0]   m_tuser,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [63:0]  cfg_data,
    input  wire logic         cfg_valid,
    input  wire logic         cfg_ready,
    output int                mismatch_count,
    output int                regions_pending
);

    localparam int STORE_DEPTH = 16;
    localparam int BOUND_DEPTH = 2 * STORE_DEPTH;
    localparam logic [31:0] CLASH_KIND = 32'd2;
    localparam logic [31:0] CLASH_ATTR = 32'd1;

    typedef struct {
        logic [63:0] base;
        logic [63:0] len;
        logic [31:0] kind;
        logic [31:0] attr;
        logic        tail;
        logic        empty;
        logic        ovf;
    } region_t;

    region_t     region_q[$];
    logic [63:0] limit;
    logic [63:0] st_base[STORE_DEPTH];
    logic [63:0] st_len[STORE_DEPTH];
    logic [31:0] st_kind[STORE_DEPTH];
    logic [31:0] st_attr[STORE_DEPTH];
    int          st_count;
    logic        dropped;

    assign regions_pending = region_q.size();

    // Sort the boundaries, classify each one and merge equal neighbors
    function automatic void build_region_list();
        logic [63:0] bnd[BOUND_DEPTH];
        logic [63:0] v;
        logic [63:0] start;
        logic [31:0] ct;
        logic [31:0] ca;
        logic [31:0] ft;
        logic [31:0] fa;
        logic        open;
        logic        found;
        logic        clash;
        int          nb;
        int          nd;
        int          j;
        int          nres;
        region_t     r;
        nb = 0;
        open = 0;
        nres = 0;
        start = '0;
        ct = '0;
        ca = '0;
        for (int i = 0; i < st_count; i++)
        begin
            if (st_base[i] > limit)
                continue;
            bnd[nb++] = st_base[i];
            if (limit - st_base[i] >= st_len[i])
                bnd[nb++] = st_base[i] + st_len[i];
        end
        for (int i = 1; i < nb; i++)
        begin
            v = bnd[i];
            j = i;
            while (j > 0 && bnd[j-1] > v)
            begin
                bnd[j] = bnd[j-1];
                j--;
            end
            bnd[j] = v;
        end
        nd = 0;
        for (int i = 0; i < nb; i++)
            if (nd == 0 || bnd[nd-1] != bnd[i])
                bnd[nd++] = bnd[i];
        for (int k = 0; k < nd; k++)
        begin
            found = 0;
            clash = 0;
            ft = '0;
            fa = '0;
            for (int i = 0; i < st_count; i++)
                if (bnd[k] >= st_base[i] && bnd[k] - st_base[i] < st_len[i])
                begin
                    if (!found)
                    begin
                        found = 1;
                        ft = st_kind[i];
                        fa = st_attr[i];
                    end
                    else if (st_kind[i] != ft || st_attr[i] != fa)
                        clash = 1;
                end
            if (clash)
            begin
                ft = CLASH_KIND;
                fa = CLASH_ATTR;
            end
            // Close the open region when the class changes
            if (open && (!found || ft != ct || fa != ca))
            begin
                r = '{start, bnd[k] - start, ct, ca, 1'b0, 1'b0, dropped};
                region_q.push_back(r);
                nres++;
                open = 0;
            end
            if (found && !open)
            begin
                open = 1;
                start = bnd[k];
                ct = ft;
                ca = fa;
            end
        end
        if (open)
        begin
            r = '{start, limit - start + 64'd1, ct, ca, 1'b0, 1'b0, dropped};
            region_q.push_back(r);
            nres++;
        end
        if (nres == 0)
        begin
            r = '{64'd0, 64'd0, 32'd0, 32'd0, 1'b1, 1'b1, dropped};
            region_q.push_back(r);
        end
        else
            region_q[$].tail = 1'b1;
    endfunction

    // Track the register, the range store and the result stream
    always @(posedge clk or negedge rst_n)
    begin
        region_t want;
        if (!rst_n)
        begin
            limit = '1;
            st_count = 0;
            dropped = 0;
            mismatch_count = 0;
            region_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                limit = cfg_data;
            if (m_tvalid && m_tready)
            begin
                if (region_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected region: data=%h last=%b user=%b",
                                 m_tdata, m_tlast, m_tuser);
                end
                else
                begin
                    want = region_q.pop_front();
                    if (m_tdata != {want.attr, want.kind, want.len, want.base}
                        || m_tlast != want.tail || m_tuser != {want.ovf, want.empty})
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"region mismatch: expected addr=%h size=%h type=%h ",
                                      "ext=%h last=%b empty=%b ovf=%b, got addr=%h ",
                                      "size=%h type=%h ext=%h last=%b empty=%b ovf=%b"},
                                     want.base, want.len, want.kind, want.attr,
                                     want.tail, want.empty, want.ovf,
                                     m_tdata[63:0], m_tdata[127:64], m_tdata[159:128],
                                     m_tdata[191:160], m_tlast, m_tuser[0], m_tuser[1]);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (st_count < STORE_DEPTH)
                begin
                    st_base[st_count] = s_tdata[63:0];
                    st_len[st_count] = s_tdata[127:64];
                    st_kind[st_count] = s_tdata[159:128];
                    st_attr[st_count] = s_tdata[191:160];
                    st_count++;
                end
                else
                    dropped = 1;
                if (s_tlast)
                begin
                    build_region_list();
                    st_count = 0;
                    dropped = 0;
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: verif/testbench.sv
// Top of the memory map sanitizer testbench: stimulus, pacing and verdict.
`timescale 1ns / 1ps
`default_nettype none

module testbench;

    localparam logic [63:0] ALL_ONES = '1;
    localparam int CYCLE_LIMIT = 2000000;

    logic         clk;
    logic         rst_n;
    logic [191:0] s_tdata;
    logic         s_tlast;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] m_tdata;
    logic         m_tlast;
    logic [1:0]   m_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  cfg_data;
    logic         cfg_valid;
    logic         cfg_ready;
    int           mismatch_count;
    int           regions_pending;
    int           ranges_sent;
    int           cycle_count;
    logic         held_off;

    memory_map_sanitizer_unit dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .m_tuser(m_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .cfg_data(cfg_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready)
    );

    msan_region_checker checker_i
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .m_tuser(m_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .cfg_data(cfg_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .mismatch_count(mismatch_count),
        .regions_pending(regions_pending)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // Pacing is steady while the calm window of requests is running
    function automatic logic calm();
        return ranges_sent >= 260 && ranges_sent < 340;
    endfunction

    // Abort on a hung run
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Receiver: random stalls, one long hold-off
    initial
    begin
        held_off = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held_off && ranges_sent >= 120)
            begin
                held_off = 1;
                m_tready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            else
                m_tready <= calm() ? 1'b1 : ($urandom_range(0, 99) >= 29);
        end
    end

    // Offer one range request and hold it until accepted
    task automatic send_range(input logic [63:0] base, input logic [63:0] len,
                              input logic [31:0] kind, input logic [31:0] attr,
                              input logic tail);
        if (!calm() && $urandom_range(0, 99) < 29)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < 29);
        end
        s_tdata <= {attr, kind, len, base};
        s_tlast <= tail;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        ranges_sent++;
    endtask

    // Drain the results, then let the block settle before a register write
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (regions_pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_limit(input logic [63:0] value);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // One random list, mostly overlapping ranges from a small pool of kinds
    task automatic send_random_list(input logic [63:0] anchor);
        int          n;
        logic [63:0] base;
        logic [63:0] len;
        logic [31:0] kind;
        logic [31:0] attr;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 19) : $urandom_range(1, 7);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 9))
                0: begin
                    base = rand64();
                    len = rand64();
                end
                1: begin
                    base = ALL_ONES - $urandom_range(0, 64);
                    len = $urandom_range(0, 128);
                end
                default: begin
                    base = anchor + $urandom_range(0, 15) * 16;
                    len = $urandom_range(0, 8) * 16;
                end
            endcase
            kind = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(1, 4);
            attr = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 1);
            send_range(base, len, kind, attr, i == n - 1);
        end
    endtask

    initial
    begin
        logic [63:0] limits[5];
        ranges_sent = 0;
        s_tdata <= '0;
        s_tlast <= 1'b0;
        s_tvalid <= 1'b0;
        cfg_data <= '0;
        cfg_valid <= 1'b0;
        rst_n <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: full space merged into one region of size zero
        send_range(64'd0, ALL_ONES, 32'd1, 32'd0, 1'b0);
        send_range(ALL_ONES, 64'd1, 32'd1, 32'd0, 1'b1);
        // Only a zero-length range gives the empty result
        send_range(64'h1000, 64'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        // Clash, merge of equal kinds, gap between neighbors
        send_range(64'h100, 64'h100, 32'd1, 32'd0, 1'b0);
        send_range(64'h180, 64'h100, 32'd3, 32'd0, 1'b0);
        send_range(64'h280, 64'h80, 32'd3, 32'd0, 1'b0);
        send_range(64'h400, 64'h10, 32'd5, 32'd7, 1'b1);
        wait_idle();
        write_limit(64'hFFF);
        // Start above the limit, end clipped at the limit
        send_range(64'h2000, 64'h10, 32'd1, 32'd0, 1'b0);
        send_range(64'hF00, 64'h1000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        // Nothing survives the limit
        send_range(64'h5000, 64'h10, 32'd1, 32'd0, 1'b1);
        // Store full: the overflow flag rides along
        for (int i = 0; i < 18; i++)
            send_range(i * 64'h40, 64'h30, i % 3, 32'd0, i == 17);
        wait_idle();

        // Random lists under several limits, extremes among them
        limits = '{ALL_ONES, 64'd0, 64'hFFFF_FFFF_FFFF_FF00, 64'h7FF, rand64()};
        for (int p = 0; p < 5; p++)
        begin
            write_limit(limits[p]);
            for (int l = 0; l < 17; l++)
                send_random_list((p == 2 && l % 2 == 0) ? ALL_ONES - 64'h180
                                                        : $urandom_range(0, 3) * 64'h80);
            wait_idle();
        end

        repeat (100) @(posedge clk);
        if (mismatch_count == 0 && regions_pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
